### src/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length palette decoder.
package pcxrle_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int COLOUR_W        = 24;
    localparam int CHAN_W          = 8;
    localparam int BYTE_W          = 8;
    localparam int DIM_W           = 17;
    localparam int REM_W           = 33;
    localparam int CNT_W           = 6;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [DIM_W-1:0]     DIM_MAX    = 17'd65536;
    localparam logic [1:0]           RUN_MARK   = 2'b11;
    localparam logic                 REQ_PALETTE = 1'b0;
    localparam logic                 REQ_DATA   = 1'b1;
    localparam logic                 CMD_WRITE  = 1'b0;
    localparam logic                 CMD_PIXEL  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;

    typedef struct packed {
        logic                req_type;
        logic [IDX_W-1:0]    palette_index;
        logic [COLOUR_W-1:0] palette_colour;
        logic [BYTE_W-1:0]   data_byte;
    } in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              run_last;
        logic              image_last;
    } out_t;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    index;
        logic [COLOUR_W-1:0] colour;
        logic [CNT_W-1:0]    count;
        logic                ends_image;
    } cmd_t;

endpackage

### src/pcx_rle_palette_decoder.sv
// Top level of the 8-bit PCX run-length decoder with palette lookup.
// Each item is either a palette write or one encoded byte. The front decodes
// runs and clips them to the remaining image size, then queues a command; the
// back end applies palette writes and emits a run's pixels at one RGB pixel
// per cycle while m_ready does not stall the output. A literal byte passes
// through a palette read, then a pixel; pixels leave through the single output
// register. A register write reloads the pixel budget from width times height,
// and no item is taken during that reload.
module pcx_rle_palette_decoder
    import pcxrle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    cmd_t head_cmd;
    logic q_empty;
    logic q_full;

    assign cfg_ready = 1'b1;

    pcxrle_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    pcxrle_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(q_cmd),
        .pop     (q_pop),
        .head_cmd(head_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    pcxrle_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head_cmd(head_cmd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### src/pcxrle_ram.sv
// Generic single-port-write, registered-read RAM.
module pcxrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/pcxrle_queue.sv
// Short command queue between the decode front and the pixel back end.
module pcxrle_queue
    import pcxrle_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/pcxrle_front.sv
// Decode front: takes items, tracks runs and the pixel budget, issues commands.
module pcxrle_front
    import pcxrle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [REM_W-1:0] remaining_reg;
    logic             run_pending_reg;
    logic [CNT_W-1:0] pending_count_reg;
    logic             reload_reg;

    logic             accept;
    logic             is_data;
    logic             header;
    logic             active;
    logic             pixel_op;
    logic [CNT_W-1:0] raw_count;
    logic [CNT_W-1:0] clipped;
    logic [DIM_W-1:0] dim_value;
    logic             cfg_hit;
    logic [2*DIM_W-1:0] product;

    assign s_ready   = !q_full && !reload_reg;
    assign accept    = s_valid && s_ready;
    assign is_data   = (s_data.req_type == REQ_DATA);
    assign header    = (s_data.data_byte[BYTE_W-1:BYTE_W-2] == RUN_MARK);
    assign active    = is_data && (remaining_reg != '0);
    assign pixel_op  = active && (run_pending_reg || !header);
    assign raw_count = run_pending_reg ? pending_count_reg : CNT_W'(1);
    assign clipped   = ({{(REM_W-CNT_W){1'b0}}, raw_count} > remaining_reg)
                       ? remaining_reg[CNT_W-1:0] : raw_count;
    assign dim_value = (cfg_wdata[DIM_W-1:0] > DIM_MAX) ? DIM_MAX : cfg_wdata[DIM_W-1:0];
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
    assign product   = {{DIM_W{1'b0}}, width_reg} * {{DIM_W{1'b0}}, height_reg};

    assign q_push = accept && (!is_data || (pixel_op && (clipped != '0)));

    always_comb begin
        q_cmd            = '0;
        q_cmd.kind       = is_data ? CMD_PIXEL : CMD_WRITE;
        q_cmd.index      = is_data ? s_data.data_byte : s_data.palette_index;
        q_cmd.colour     = s_data.palette_colour;
        q_cmd.count      = clipped;
        q_cmd.ends_image = ({{(REM_W-CNT_W){1'b0}}, clipped} == remaining_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg         <= DIM_W'(1);
            height_reg        <= DIM_W'(1);
            remaining_reg     <= REM_W'(1);
            run_pending_reg   <= 1'b0;
            pending_count_reg <= '0;
            reload_reg        <= 1'b0;
        end else begin
            reload_reg <= cfg_hit;
            if (cfg_hit) begin
                if (cfg_index == REG_WIDTH) begin
                    width_reg <= dim_value;
                end else begin
                    height_reg <= dim_value;
                end
                run_pending_reg   <= 1'b0;
                pending_count_reg <= '0;
            end else if (reload_reg) begin
                remaining_reg <= product[REM_W-1:0];
            end else if (accept && active) begin
                if (run_pending_reg) begin
                    run_pending_reg   <= 1'b0;
                    pending_count_reg <= '0;
                end else if (header) begin
                    run_pending_reg   <= 1'b1;
                    pending_count_reg <= s_data.data_byte[CNT_W-1:0];
                end
                if (pixel_op) begin
                    remaining_reg <= remaining_reg - {{(REM_W-CNT_W){1'b0}}, clipped};
                end
            end
        end
    end

endmodule

### src/pcxrle_back.sv
// Pixel back end: applies palette writes and expands runs into pixels.
module pcxrle_back
    import pcxrle_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t head_cmd,
    input  logic q_empty,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                ends_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;
    logic [COLOUR_W-1:0] colour;
    logic                ram_we;
    logic                ram_re;
    logic                out_free;
    logic                emit;
    logic                last_pix;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign ram_we   = q_pop && (head_cmd.kind == CMD_WRITE);
    assign ram_re   = q_pop && (head_cmd.kind == CMD_PIXEL);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg == ST_EMIT) && out_free;
    assign last_pix = (cnt_reg == CNT_W'(1));

    pcxrle_ram #(
        .WIDTH(COLOUR_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(head_cmd.index),
        .wdata(head_cmd.colour),
        .re   (ram_re),
        .raddr(head_cmd.index),
        .rdata(colour)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (ram_re) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit && last_pix) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ends_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ram_re) begin
                cnt_reg  <= head_cmd.count;
                ends_reg <= head_cmd.ends_image;
            end else if (emit) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.red        <= colour[3*CHAN_W-1:2*CHAN_W];
            m_data_reg.green      <= colour[2*CHAN_W-1:CHAN_W];
            m_data_reg.blue       <= colour[CHAN_W-1:0];
            m_data_reg.run_last   <= last_pix;
            m_data_reg.image_last <= last_pix && ends_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
